>>> src/bzh_pkg.sv
// Shared constants for the board Zobrist hash unit.
// Key table geometry and the layout of the non-piece keys.
// No dependencies.
package bzh_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int KEY_W       = 64;
   localparam int SQUARES     = 64;
   localparam int SQ_W        = $clog2(SQUARES);
   localparam int KINDS       = 6;
   localparam int KIND_W      = 3;

   localparam int KEY_WORDS   = 793;
   localparam int SIDE_BASE   = 768;
   localparam int CASTLE_BASE = 769;
   localparam int EP_BASE     = 785;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [SQUARES-1:0] board_type;

   localparam addr_type LAST_WORD_ADDR = addr_type'(KEY_WORDS - 1);
   localparam addr_type SIDE_ADDR      = addr_type'(SIDE_BASE);
   localparam addr_type CASTLE_ADDR    = addr_type'(CASTLE_BASE);
   localparam addr_type EP_ADDR        = addr_type'(EP_BASE);

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_HASH = 1'b1;

endpackage

>>> src/board_zobrist_hash_unit.sv
// Board Zobrist hash unit: key table memory, load pointer and hash sequencer.
// Depends on bzh_pkg.
//
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  action, table word, board fields
// rsp      out  rsp_valid/rsp_ready  hash_key (hash beats only)
//
// A hash beat makes one key-table read per set bit over the six piece
// bitboards: one key-table read per cycle through the single registered
// read port, with a pass step for each bitboard.
// Reset clears the load pointer and the sequencer; the table keeps no reset.
// A finished key waits in the output register; the next hash holds in its
// last step while that key is not yet taken.
module board_zobrist_hash_unit
   import bzh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [63:0] req_table_word,
   input  logic [63:0] req_pawn_squares,
   input  logic [63:0] req_knight_squares,
   input  logic [63:0] req_bishop_squares,
   input  logic [63:0] req_rook_squares,
   input  logic [63:0] req_queen_squares,
   input  logic [63:0] req_king_squares,
   input  logic [63:0] req_white_squares,
   input  logic        req_white_to_move,
   input  logic [5:0]  req_ep_square,
   input  logic [3:0]  req_castling_rights,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_key
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_EXTRA = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [1:0] STEP_SIDE   = 2'd0;
   localparam logic [1:0] STEP_EP     = 2'd1;
   localparam logic [1:0] STEP_CASTLE = 2'd2;

   localparam logic [KIND_W-1:0] LAST_KIND = KIND_W'(KINDS - 1);

   key_type mem [TABLE_DEPTH];

   logic [2:0]        state_ff, state_in;
   addr_type          ptr_ff, ptr_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [1:0]        step_ff, step_in;
   board_type         rem_ff, rem_in;
   board_type         board_ff [KINDS];
   board_type         white_ff;
   logic              wtm_ff;
   logic [5:0]        ep_ff;
   logic [3:0]        castle_ff;
   key_type           acc_ff, acc_in;
   logic              pend_ff;
   key_type           rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   key_type           rsp_key_ff;

   logic              req_fire;
   logic              wr_en;
   logic              rd_en;
   addr_type          rd_addr;
   board_type         lowest;
   logic [SQ_W-1:0]   sq_idx;
   logic              colour;
   logic              result_load;

   assign req_ready    = (state_ff == ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign wr_en        = req_fire && (req_action == ACTION_LOAD);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hash_key = rsp_key_ff;

   assign lowest = rem_ff & (~rem_ff + board_type'(1));
   assign colour = ~|(white_ff & lowest);

   always_comb begin
      sq_idx = '0;
      for (int i = 0; i < SQUARES; i++) begin
         if (lowest[i]) begin
            sq_idx = sq_idx | SQ_W'(i);
         end
      end
   end

   assign result_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      kind_in  = kind_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      acc_in   = pend_ff ? (acc_ff ^ rd_data_ff) : acc_ff;
      rd_en    = 1'b0;
      rd_addr  = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (wr_en) begin
               ptr_in = (ptr_ff == LAST_WORD_ADDR) ? '0 : ptr_ff + addr_type'(1);
            end else if (req_fire) begin
               state_in = ST_SCAN;
               kind_in  = '0;
               rem_in   = req_pawn_squares;
               acc_in   = '0;
            end
         end
         ST_SCAN: begin
            if (rem_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = {kind_ff, colour, sq_idx};
               rem_in  = rem_ff ^ lowest;
            end else if (kind_ff == LAST_KIND) begin
               state_in = ST_EXTRA;
               step_in  = STEP_SIDE;
            end else begin
               kind_in = kind_ff + KIND_W'(1);
               rem_in  = board_ff[kind_ff + KIND_W'(1)];
            end
         end
         ST_EXTRA: begin
            case (step_ff)
               STEP_SIDE: begin
                  rd_en   = wtm_ff;
                  rd_addr = SIDE_ADDR;
                  step_in = STEP_EP;
               end
               STEP_EP: begin
                  rd_en   = (ep_ff != '0);
                  rd_addr = EP_ADDR + addr_type'(ep_ff[2:0]);
                  step_in = STEP_CASTLE;
               end
               default: begin
                  rd_en    = 1'b1;
                  rd_addr  = CASTLE_ADDR + addr_type'(castle_ff);
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (result_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      if (result_load) begin
         rsp_key_ff <= acc_ff;
      end
      if (req_fire && (req_action == ACTION_HASH)) begin
         board_ff[0] <= req_pawn_squares;
         board_ff[1] <= req_knight_squares;
         board_ff[2] <= req_bishop_squares;
         board_ff[3] <= req_rook_squares;
         board_ff[4] <= req_queen_squares;
         board_ff[5] <= req_king_squares;
         white_ff    <= req_white_squares;
         wtm_ff      <= req_white_to_move;
         ep_ff       <= req_ep_square;
         castle_ff   <= req_castling_rights;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[ptr_ff] <= req_table_word;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
